// File: design/telegram_decimal_checksum_macros.svh
// Assertion macros for the checker module of the telegram checksum block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef TELEGRAM_DECIMAL_CHECKSUM_MACROS_SVH
`define TELEGRAM_DECIMAL_CHECKSUM_MACROS_SVH

// Same-cycle or multi-cycle property, sampled on clk, off during reset.
`define TDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: when ante holds, cons must hold on the following edge.
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tdc_pkg.sv
// Shared types and constants for the telegram decimal checksum block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tdc_pkg;

    localparam logic [7:0] TERM_BYTE  = 8'h0D;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Work orders passed from the front to the back.
    typedef enum logic [1:0] {
        OP_ECHO,
        OP_ECHO_LAST,
        OP_VERDICT
    } tdc_op_kind_t;

    typedef struct packed {
        tdc_op_kind_t kind;
        logic [7:0]   data;
        logic [7:0]   sum;
        logic         ok;
    } tdc_op_t;

    // One result word as shown on the output side.
    typedef struct packed {
        logic [7:0] data;
        logic       is_verdict;
        logic       ok;
        logic       eor;
    } tdc_result_t;

    // Back-end sequencer: pass queue entries through, or spell out the checksum.
    typedef enum logic [2:0] {
        BK_PASS,
        BK_HUNDREDS,
        BK_TENS,
        BK_UNITS,
        BK_TERM
    } tdc_back_state_t;

endpackage

// File: design/tdc_front.sv
// Front end: takes input words, keeps the running sum and tail window, and
// queues every word in generate mode but only terminators in check mode. Depends on tdc_pkg.
module tdc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    input  logic [7:0]        in_data,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output tdc_pkg::tdc_op_t  q_entry
);

    logic        mode_reg;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  win_reg [3];
    logic [7:0]  win_next [3];
    logic [1:0]  seen_reg, seen_next;
    logic        accept;
    logic        is_term;
    logic signed [15:0] d2e, d1e, d0e, supplied;
    logic        verdict_ok;

    assign accept  = in_valid && !q_full;
    assign is_term = (in_data == tdc_pkg::TERM_BYTE);

    assign d2e = $signed({8'h00, win_reg[2]}) - $signed({8'h00, tdc_pkg::ASCII_ZERO});
    assign d1e = $signed({8'h00, win_reg[1]}) - $signed({8'h00, tdc_pkg::ASCII_ZERO});
    assign d0e = $signed({8'h00, win_reg[0]}) - $signed({8'h00, tdc_pkg::ASCII_ZERO});
    assign supplied = d2e * 16'sd100 + d1e * 16'sd10 + d0e;
    assign verdict_ok = (seen_reg == 2'd3) && (supplied == $signed({8'h00, sum_reg}));

    always_comb
    begin
        sum_next    = sum_reg;
        win_next[0] = win_reg[0];
        win_next[1] = win_reg[1];
        win_next[2] = win_reg[2];
        seen_next   = seen_reg;
        q_push      = 1'b0;
        q_entry     = '{kind: tdc_pkg::OP_ECHO, data: in_data, sum: 8'h00, ok: 1'b0};
        if (accept)
        begin
            if (mode_reg)
            begin
                q_push      = 1'b1;
                q_entry.sum = sum_reg + in_data;
                if (in_last)
                begin
                    q_entry.kind = tdc_pkg::OP_ECHO_LAST;
                    sum_next     = 8'h00;
                end
                else
                begin
                    sum_next = sum_reg + in_data;
                end
            end
            else if (is_term)
            begin
                q_push      = 1'b1;
                q_entry     = '{kind: tdc_pkg::OP_VERDICT, data: tdc_pkg::TERM_BYTE,
                                sum: sum_reg, ok: verdict_ok};
                sum_next    = 8'h00;
                win_next[0] = 8'h00;
                win_next[1] = 8'h00;
                win_next[2] = 8'h00;
                seen_next   = 2'd0;
            end
            else
            begin
                // The oldest window byte joins the sum once three are held.
                if (seen_reg == 2'd3)
                begin
                    sum_next = sum_reg + win_reg[2];
                end
                else
                begin
                    seen_next = seen_reg + 2'd1;
                end
                win_next[2] = win_reg[1];
                win_next[1] = win_reg[0];
                win_next[0] = in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            sum_reg    <= 8'h00;
            win_reg[0] <= 8'h00;
            win_reg[1] <= 8'h00;
            win_reg[2] <= 8'h00;
            seen_reg   <= 2'd0;
        end
        else if (cfg_wen)
        begin
            mode_reg   <= cfg_wdata;
            sum_reg    <= 8'h00;
            win_reg[0] <= 8'h00;
            win_reg[1] <= 8'h00;
            win_reg[2] <= 8'h00;
            seen_reg   <= 2'd0;
        end
        else
        begin
            sum_reg    <= sum_next;
            win_reg[0] <= win_next[0];
            win_reg[1] <= win_next[1];
            win_reg[2] <= win_next[2];
            seen_reg   <= seen_next;
        end
    end

endmodule

// File: design/tdc_queue.sv
// Short queue of operations between the front and back ends.
// Depends on tdc_pkg for the entry type and depth.
module tdc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tdc_pkg::tdc_op_t  wr_entry,
    output logic              full,
    input  logic              pop,
    output tdc_pkg::tdc_op_t  rd_entry,
    output logic              empty
);

    tdc_pkg::tdc_op_t                  slot_reg [tdc_pkg::QUEUE_DEPTH];
    logic [tdc_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [tdc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign full     = (count_reg == tdc_pkg::QCNT_W'(tdc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// File: design/tdc_back.sv
// Back end: drains queued operations into the output register, following a
// final payload byte with three ASCII checksum digits and a terminator. Depends on tdc_pkg.
module tdc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdc_pkg::tdc_op_t      q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output tdc_pkg::tdc_result_t  res,
    output logic                  res_empty,
    input  logic                  res_pop
);

    tdc_pkg::tdc_back_state_t state_reg, state_next;
    logic [7:0]           sum_reg;
    logic                 out_valid_reg;
    tdc_pkg::tdc_result_t out_reg;
    tdc_pkg::tdc_result_t res_next;
    logic                 res_next_valid;
    logic                 slot_free;
    logic                 load_last;

    logic [1:0]  hundreds;
    logic [6:0]  rem100;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  units;

    // Decimal digits of the stored sum: compares for hundreds, reciprocal
    // multiply for tens (exact for values below 100).
    always_comb
    begin
        if (sum_reg >= 8'd200)
        begin
            hundreds = 2'd2;
            rem100   = 7'(sum_reg - 8'd200);
        end
        else if (sum_reg >= 8'd100)
        begin
            hundreds = 2'd1;
            rem100   = 7'(sum_reg - 8'd100);
        end
        else
        begin
            hundreds = 2'd0;
            rem100   = sum_reg[6:0];
        end
        tens_prod = {8'h00, rem100} * 15'd205;
        tens      = 4'(tens_prod >> 11);
        units     = 4'(rem100 - {3'b000, tens} * 7'd10);
    end

    assign slot_free = !out_valid_reg || res_pop;
    assign load_last = (state_reg == tdc_pkg::BK_PASS) && slot_free && !q_empty
                       && (q_head.kind == tdc_pkg::OP_ECHO_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdc_pkg::BK_PASS:     if (load_last) state_next = tdc_pkg::BK_HUNDREDS;
            tdc_pkg::BK_HUNDREDS: if (slot_free) state_next = tdc_pkg::BK_TENS;
            tdc_pkg::BK_TENS:     if (slot_free) state_next = tdc_pkg::BK_UNITS;
            tdc_pkg::BK_UNITS:    if (slot_free) state_next = tdc_pkg::BK_TERM;
            tdc_pkg::BK_TERM:     if (slot_free) state_next = tdc_pkg::BK_PASS;
            default:              state_next = tdc_pkg::BK_PASS;
        endcase
    end

    always_comb
    begin
        res_next       = '{data: 8'h00, is_verdict: 1'b0, ok: 1'b0, eor: 1'b0};
        res_next_valid = 1'b1;
        q_pop          = 1'b0;
        unique case (state_reg)
            tdc_pkg::BK_PASS:
            begin
                res_next_valid = !q_empty;
                q_pop          = slot_free;
                if (q_head.kind == tdc_pkg::OP_VERDICT)
                begin
                    res_next = '{data: tdc_pkg::TERM_BYTE, is_verdict: 1'b1,
                                 ok: q_head.ok, eor: 1'b1};
                end
                else
                begin
                    res_next.data = q_head.data;
                end
            end
            tdc_pkg::BK_HUNDREDS:
                res_next.data = tdc_pkg::ASCII_ZERO + {6'h00, hundreds};
            tdc_pkg::BK_TENS:
                res_next.data = tdc_pkg::ASCII_ZERO + {4'h0, tens};
            tdc_pkg::BK_UNITS:
                res_next.data = tdc_pkg::ASCII_ZERO + {4'h0, units};
            tdc_pkg::BK_TERM:
            begin
                res_next.data = tdc_pkg::TERM_BYTE;
                res_next.eor  = 1'b1;
            end
            default:
                res_next_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdc_pkg::BK_PASS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (slot_free)
            begin
                out_valid_reg <= res_next_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_reg <= res_next;
        end
        if (load_last)
        begin
            sum_reg <= q_head.sum;
        end
    end

    assign res       = out_reg;
    assign res_empty = !out_valid_reg;

endmodule

// File: design/telegram_decimal_checksum.sv
// Channel    Handshake            Contents
// input      push / full          data_byte, last
// result     empty / pop          out_byte, is_verdict, checksum_ok, end_of_run
// config     cfg_wen              cfg_wdata (mode: 0 check, 1 generate)
//
// One input word is taken per cycle while the operation queue has room; each
// result word leaves the output register when pop is high. A final payload byte in
// generate mode keeps the back-end sequencer busy through the echo, three digits
// and terminator, so input stalls once the queue fills.
// Reset is asynchronous, active low, and clears mode and all telegram state.
// A mode write clears the telegram state of the front end.
module telegram_decimal_checksum (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       is_verdict,
    output logic       checksum_ok,
    output logic       end_of_run
);

    logic                 q_full, q_empty, q_push, q_pop;
    tdc_pkg::tdc_op_t     q_wr, q_rd;
    tdc_pkg::tdc_result_t res;

    assign full = q_full;

    tdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (push),
        .in_data   (data_byte),
        .in_last   (last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_wr)
    );

    tdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd),
        .empty    (q_empty)
    );

    tdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_rd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign out_byte    = res.data;
    assign is_verdict  = res.is_verdict;
    assign checksum_ok = res.ok;
    assign end_of_run  = res.eor;

endmodule

// File: design/telegram_decimal_checksum_checker.sv
// Port-level checker for the telegram checksum block, bound to the top level.
// Depends on tdc_pkg and telegram_decimal_checksum_macros.svh.
`include "telegram_decimal_checksum_macros.svh"

module telegram_decimal_checksum_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       is_verdict,
    input logic       checksum_ok,
    input logic       end_of_run
);

    // A verdict always closes a telegram and carries the terminator byte.
    `TDC_ASSERT(a_verdict_form, !empty && is_verdict |-> end_of_run && out_byte == tdc_pkg::TERM_BYTE, "verdict word malformed")

    // A pass flag only appears on a verdict word.
    `TDC_ASSERT(a_ok_only_verdict, !empty && checksum_ok |-> is_verdict, "checksum_ok on a byte word")

    // In generate mode the end of a telegram is the terminator byte.
    `TDC_ASSERT(a_term_at_end, !empty && end_of_run && !is_verdict |-> out_byte == tdc_pkg::TERM_BYTE, "end_of_run on a non-terminator byte")

    // A waiting word stays put until it is taken.
    `TDC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(end_of_run), "result word changed while stalled")

endmodule

bind telegram_decimal_checksum telegram_decimal_checksum_checker u_checker (.*);
